[rtl/hbp_pkg.sv]
// Shared constants and types of the Huffman bit packer.
`timescale 1ns / 1ps
`default_nettype none
package hbp_pkg;

   localparam int OP_W             = 2;
   localparam int SYM_W            = 8;
   localparam int LEN_IN_W         = 5;
   localparam int PATTERN_BITS     = 16;
   localparam int OUT_W            = 32;
   localparam int PAD_W            = 64;
   localparam int LIMIT_W          = 6;
   localparam int TABLE_DEPTH      = 256;
   localparam int FIFO_DEPTH       = 4;
   localparam int MAX_CODE_BITS_DEF = 16;
   localparam int WORD_BITS_DEF    = 32;

   localparam logic [SYM_W-1:0] END_SYMBOL_RESET = 8'd127;

   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
   localparam logic [OP_W-1:0] OP_END    = 2'd2;

   typedef struct packed {
      logic [OUT_W-1:0] word;
      logic             final_word;
   } hbp_out_type;

   typedef struct packed {
      logic push_a;
      logic push_b;
   } hbp_push_type;

endpackage
`default_nettype wire

[rtl/hbp_if.sv]
// Handshake interfaces for the request, response and register channels.
`timescale 1ns / 1ps
`default_nettype none
interface hbp_req_if import hbp_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         opcode;
   logic [SYM_W-1:0]        symbol;
   logic [LEN_IN_W-1:0]     code_length;
   logic [PATTERN_BITS-1:0] code_pattern;
   modport source (output valid, opcode, symbol, code_length, code_pattern, input ready);
   modport sink (input valid, opcode, symbol, code_length, code_pattern, output ready);
endinterface

interface hbp_rsp_if import hbp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] packed_word;
   logic             final_word;
   modport source (output valid, packed_word, final_word, input ready);
   modport sink (input valid, packed_word, final_word, output ready);
endinterface

interface hbp_csr_if import hbp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] end_symbol;
   modport source (output valid, end_symbol, input ready);
   modport sink (input valid, end_symbol, output ready);
endinterface
`default_nettype wire

[rtl/hbp_code_table.sv]
// Code table memory with per-entry valid bits and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module hbp_code_table import hbp_pkg::*; #(
   parameter int LEN_LIMIT = MAX_CODE_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 wr_en,
   input  wire logic [SYM_W-1:0]                     wr_addr,
   input  wire logic [LEN_IN_W-1:0]                  wr_len,
   input  wire logic [PATTERN_BITS-1:0]              wr_pat,
   input  wire logic                                 rd_en,
   input  wire logic [SYM_W-1:0]                     rd_addr,
   output logic [$clog2(LEN_LIMIT+1)-1:0]            rd_len,
   output logic [PATTERN_BITS-1:0]                   rd_pat
);
   localparam int LEN_W   = $clog2(LEN_LIMIT + 1);
   localparam int ENTRY_W = LEN_W + PATTERN_BITS;

   logic [ENTRY_W-1:0]     mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [ENTRY_W-1:0]     rd_data_ff;
   logic                   rd_valid_ff;
   logic [LIMIT_W-1:0]     len_ext;
   logic [LIMIT_W-1:0]     len_clamp;
   logic [PATTERN_BITS-1:0] keep;
   logic [ENTRY_W-1:0]     wr_data;

   always_comb begin
      len_ext   = LIMIT_W'(wr_len);
      len_clamp = (len_ext > LIMIT_W'(LEN_LIMIT)) ? LIMIT_W'(LEN_LIMIT) : len_ext;
      keep      = ~({PATTERN_BITS{1'b1}} >> len_clamp);
      wr_data   = {LEN_W'(len_clamp), wr_pat & keep};
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_len = rd_valid_ff ? rd_data_ff[ENTRY_W-1:PATTERN_BITS] : '0;
   assign rd_pat = rd_valid_ff ? rd_data_ff[PATTERN_BITS-1:0] : '0;

endmodule
`default_nettype wire

[rtl/hbp_packer.sv]
// Shift-merge stage: appends looked-up codes to the bit buffer and emits words.
`timescale 1ns / 1ps
`default_nettype none
module hbp_packer import hbp_pkg::*; #(
   parameter int LEN_LIMIT = MAX_CODE_BITS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire logic                              in_end,
   output logic                                   in_ready,
   input  wire logic [$clog2(LEN_LIMIT+1)-1:0]    rd_len,
   input  wire logic [PATTERN_BITS-1:0]           rd_pat,
   input  wire logic                              room,
   output hbp_push_type                           push,
   output hbp_out_type                            out_a,
   output hbp_out_type                            out_b
);
   localparam int LEN_W  = $clog2(LEN_LIMIT + 1);
   localparam int FILL_W = $clog2(WORD_BITS + 1);
   localparam int SUM_W  = $clog2(WORD_BITS + LEN_LIMIT + 1);

   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_end_ff, s1_end_in;
   logic [WORD_BITS-1:0]   buf_ff, buf_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic                   go;
   logic [SUM_W-1:0]       sum;
   logic                   ovf;
   logic [2*WORD_BITS-1:0] dbl_code;
   logic [2*WORD_BITS-1:0] shifted;
   logic [WORD_BITS-1:0]   merged;
   logic [WORD_BITS-1:0]   spill;
   logic [PAD_W-1:0]       merged_pad;
   logic [PAD_W-1:0]       spill_pad;

   always_comb begin
      go         = s1_valid_ff && room;
      in_ready   = !s1_valid_ff || go;
      sum        = SUM_W'(fill_ff) + SUM_W'(rd_len);
      ovf        = sum > SUM_W'(WORD_BITS);
      dbl_code   = {rd_pat, {(2*WORD_BITS-PATTERN_BITS){1'b0}}};
      shifted    = dbl_code >> fill_ff;
      merged     = buf_ff | shifted[2*WORD_BITS-1:WORD_BITS];
      spill      = shifted[WORD_BITS-1:0];
      merged_pad = PAD_W'(merged);
      spill_pad  = PAD_W'(spill);

      push.push_a      = go && (ovf || s1_end_ff);
      push.push_b      = go && ovf && s1_end_ff;
      out_a.word       = merged_pad[OUT_W-1:0];
      out_a.final_word = s1_end_ff && !ovf;
      out_b.word       = spill_pad[OUT_W-1:0];
      out_b.final_word = 1'b1;

      buf_in  = buf_ff;
      fill_in = fill_ff;
      if (go) begin
         if (s1_end_ff) begin
            buf_in  = '0;
            fill_in = '0;
         end else if (ovf) begin
            buf_in  = spill;
            fill_in = FILL_W'(sum - SUM_W'(WORD_BITS));
         end else begin
            buf_in  = merged;
            fill_in = FILL_W'(sum);
         end
      end

      s1_valid_in = s1_valid_ff;
      s1_end_in   = s1_end_ff;
      if (in_ready) begin
         s1_valid_in = in_valid;
         s1_end_in   = in_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_end_ff   <= 1'b0;
         buf_ff      <= '0;
         fill_ff     <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s1_end_ff   <= s1_end_in;
         buf_ff      <= buf_in;
         fill_ff     <= fill_in;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WORD_BITS))
      else $error("fill count exceeds word size");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      go && s1_end_ff |=> fill_ff == '0 && buf_ff == '0)
      else $error("end item left bits in the buffer");

endmodule
`default_nettype wire

[rtl/hbp_out_fifo.sv]
// Result queue taking up to two words per cycle and draining one while out_ready is high.
`timescale 1ns / 1ps
`default_nettype none
module hbp_out_fifo import hbp_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire hbp_push_type push,
   input  wire hbp_out_type  data_a,
   input  wire hbp_out_type  data_b,
   output logic              room,
   output logic              out_valid,
   input  wire logic         out_ready,
   output hbp_out_type       out_data
);
   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   hbp_out_type      mem [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;
   logic [CNT_W-1:0] n_push;

   always_comb begin
      out_valid = count_ff != '0;
      out_data  = mem[rd_ptr_ff];
      room      = count_ff <= CNT_W'(FIFO_DEPTH - 2);
      pop       = out_valid && out_ready;
      n_push    = CNT_W'(push.push_a) + CNT_W'(push.push_b);
      wr_ptr_in = wr_ptr_ff + PTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + n_push - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.push_a) begin
         mem[wr_ptr_ff] <= data_a;
      end
      if (push.push_b) begin
         mem[wr_ptr_ff + PTR_W'(1)] <= data_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("result queue overflow");

   a_push_order: assert property (@(posedge clock) disable iff (reset)
      push.push_b |-> push.push_a)
      else $error("second word pushed without first");

endmodule
`default_nettype wire

[rtl/huffman_bit_packer_core.sv]
// Top level of the table-driven Huffman bit packer.
// Throughput: one item per cycle while the result queue has room; an end item that
// yields two words pushes both at once, and the queue drains one word per cycle while rsp is ready.
// An accepted item passes the table read register, then the shift-merge into the
// result queue, before its word is offered on rsp.
// Reset clears all table valid bits and the buffer, and sets end_symbol to 127.
`timescale 1ns / 1ps
`default_nettype none
module huffman_bit_packer_core import hbp_pkg::*; #(
   parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
   parameter int WORD_BITS     = WORD_BITS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   hbp_req_if.sink     req_bus,
   hbp_rsp_if.source   rsp_bus,
   hbp_csr_if.sink     csr_bus
);
   localparam int LEN_LIMIT = (MAX_CODE_BITS < WORD_BITS) ? MAX_CODE_BITS : WORD_BITS;
   localparam int LEN_W     = $clog2(LEN_LIMIT + 1);

   logic [SYM_W-1:0]        end_symbol_ff, end_symbol_in;
   logic                    req_ok;
   logic                    op_load;
   logic                    op_pack;
   logic                    op_end;
   logic [SYM_W-1:0]        rd_addr;
   logic [LEN_W-1:0]        rd_len;
   logic [PATTERN_BITS-1:0] rd_pat;
   logic                    pk_ready;
   logic                    room;
   hbp_push_type            push;
   hbp_out_type             out_a;
   hbp_out_type             out_b;
   hbp_out_type             head;

   always_comb begin
      op_load = 1'b0;
      op_pack = 1'b0;
      op_end  = 1'b0;
      unique case (req_bus.opcode)
         OP_LOAD: begin
            op_load = 1'b1;
         end
         OP_ENCODE: begin
            op_pack = 1'b1;
         end
         OP_END: begin
            op_pack = 1'b1;
            op_end  = 1'b1;
         end
         default: begin
         end
      endcase
      req_ok        = req_bus.valid && pk_ready;
      rd_addr       = op_end ? end_symbol_ff : req_bus.symbol;
      end_symbol_in = (csr_bus.valid) ? csr_bus.end_symbol : end_symbol_ff;
   end

   assign req_bus.ready = pk_ready;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         end_symbol_ff <= END_SYMBOL_RESET;
      end else begin
         end_symbol_ff <= end_symbol_in;
      end
   end

   hbp_code_table #(
      .LEN_LIMIT (LEN_LIMIT)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_ok && op_load),
      .wr_addr (req_bus.symbol),
      .wr_len  (req_bus.code_length),
      .wr_pat  (req_bus.code_pattern),
      .rd_en   (req_ok),
      .rd_addr (rd_addr),
      .rd_len  (rd_len),
      .rd_pat  (rd_pat)
   );

   hbp_packer #(
      .LEN_LIMIT (LEN_LIMIT),
      .WORD_BITS (WORD_BITS)
   ) u_packer (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ok && op_pack),
      .in_end   (op_end),
      .in_ready (pk_ready),
      .rd_len   (rd_len),
      .rd_pat   (rd_pat),
      .room     (room),
      .push     (push),
      .out_a    (out_a),
      .out_b    (out_b)
   );

   hbp_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .data_a    (out_a),
      .data_b    (out_b),
      .room      (room),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (head)
   );

   assign rsp_bus.packed_word = head.word;
   assign rsp_bus.final_word  = head.final_word;

endmodule
`default_nettype wire
